### design/sslc_pkg.sv
// shared types, constants and helpers for the screen lift controller
package sslc_pkg;

   localparam int STEP_COUNT_WIDTH = 24;
   localparam int TIMER_WIDTH      = 20;

   localparam int DIV_WIDTH     = 16;
   localparam int BOTTOM_WIDTH  = 24;
   localparam int TICKS_WIDTH   = 20;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam logic [DIV_WIDTH-1:0]    STEP_DIVIDER_RESET      = 16'd0;
   localparam logic [BOTTOM_WIDTH-1:0] BOTTOM_STEPS_RESET      = 24'd14000000;
   localparam logic [TICKS_WIDTH-1:0]  CONFIRM_ON_TICKS_RESET  = 20'd59259;
   localparam logic [TICKS_WIDTH-1:0]  CONFIRM_OFF_TICKS_RESET = 20'd118519;
   localparam logic [TICKS_WIDTH-1:0]  JOG_TICKS_RESET         = 20'd11852;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_STEP_DIVIDER      = 3'd0,
      REG_BOTTOM_STEPS      = 3'd1,
      REG_CONFIRM_ON_TICKS  = 3'd2,
      REG_CONFIRM_OFF_TICKS = 3'd3,
      REG_JOG_TICKS         = 3'd4
   } reg_index_type;

   typedef enum logic [2:0] {
      MODE_INIT     = 3'd0,
      MODE_LOWERING = 3'd1,
      MODE_RAISING  = 3'd2,
      MODE_DOWN     = 3'd3,
      MODE_UP       = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      WAIT_NONE     = 2'd0,
      WAIT_CONFIRM  = 2'd1,
      WAIT_JOG_DOWN = 2'd2,
      WAIT_JOG_UP   = 2'd3
   } wait_kind_type;

   typedef struct packed {
      logic [DIV_WIDTH-1:0]    step_divider;
      logic [BOTTOM_WIDTH-1:0] bottom_steps;
      logic [TICKS_WIDTH-1:0]  confirm_on_ticks;
      logic [TICKS_WIDTH-1:0]  confirm_off_ticks;
      logic [TICKS_WIDTH-1:0]  jog_ticks;
   } cfg_type;

   typedef struct packed {
      logic projector_on;
      logic at_top;
      logic jog_down_pressed;
      logic jog_up_pressed;
   } tick_type;

   typedef struct packed {
      logic     step_level;
      logic     direction_down;
      logic     motor_enable;
      mode_type mode_code;
   } result_type;

   // delay values beyond the timer range load as the timer maximum
   function automatic logic [TIMER_WIDTH-1:0] clamp_ticks(input logic [TICKS_WIDTH-1:0] ticks);
      logic [32:0] wide;
      logic [32:0] lim;
      wide = 33'(ticks);
      lim  = 33'({TIMER_WIDTH{1'b1}});
      if (wide > lim) begin
         clamp_ticks = {TIMER_WIDTH{1'b1}};
      end else begin
         clamp_ticks = TIMER_WIDTH'(ticks);
      end
   endfunction

endpackage

### design/sslc_csr.sv
// configuration register bank with apb-style access
module sslc_csr
   import sslc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready,
   output cfg_type                   cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign index  = reg_index_type'(paddr[CSR_ADDR_WIDTH-1:2]);
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_STEP_DIVIDER:      cfg_in.step_divider      = pwdata[DIV_WIDTH-1:0];
            REG_BOTTOM_STEPS:      cfg_in.bottom_steps      = pwdata[BOTTOM_WIDTH-1:0];
            REG_CONFIRM_ON_TICKS:  cfg_in.confirm_on_ticks  = pwdata[TICKS_WIDTH-1:0];
            REG_CONFIRM_OFF_TICKS: cfg_in.confirm_off_ticks = pwdata[TICKS_WIDTH-1:0];
            REG_JOG_TICKS:         cfg_in.jog_ticks         = pwdata[TICKS_WIDTH-1:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_STEP_DIVIDER:      prdata = CSR_DATA_WIDTH'(cfg_ff.step_divider);
         REG_BOTTOM_STEPS:      prdata = CSR_DATA_WIDTH'(cfg_ff.bottom_steps);
         REG_CONFIRM_ON_TICKS:  prdata = CSR_DATA_WIDTH'(cfg_ff.confirm_on_ticks);
         REG_CONFIRM_OFF_TICKS: prdata = CSR_DATA_WIDTH'(cfg_ff.confirm_off_ticks);
         REG_JOG_TICKS:         prdata = CSR_DATA_WIDTH'(cfg_ff.jog_ticks);
         default:               prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_divider      <= STEP_DIVIDER_RESET;
         cfg_ff.bottom_steps      <= BOTTOM_STEPS_RESET;
         cfg_ff.confirm_on_ticks  <= CONFIRM_ON_TICKS_RESET;
         cfg_ff.confirm_off_ticks <= CONFIRM_OFF_TICKS_RESET;
         cfg_ff.jog_ticks         <= JOG_TICKS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### design/sslc_core.sv
// step divider, edge counter, wait timer and control state machine
module sslc_core
   import sslc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  tick_type   tick,
   input  cfg_type    cfg,
   output result_type result
);

   localparam logic [STEP_COUNT_WIDTH-1:0] EDGES_MAX = {STEP_COUNT_WIDTH{1'b1}};

   mode_type                    mode_ff, mode_in;
   wait_kind_type               wait_kind_ff, wait_kind_in;
   logic                        step_pin_ff, step_pin_in;
   logic [DIV_WIDTH-1:0]        div_cnt_ff, div_cnt_in;
   logic [STEP_COUNT_WIDTH-1:0] edges_ff, edges_in;
   logic                        counting_ff, counting_in;
   logic [TIMER_WIDTH-1:0]      timer_ff, timer_in;
   logic                        dir_ff, dir_in;
   logic                        enable_ff, enable_in;

   always_comb begin
      logic jog_check;
      logic up_check;
      logic below_bottom;
      jog_check    = 1'b0;
      up_check     = 1'b0;
      mode_in      = mode_ff;
      wait_kind_in = wait_kind_ff;
      step_pin_in  = step_pin_ff;
      div_cnt_in   = div_cnt_ff;
      edges_in     = edges_ff;
      counting_in  = counting_ff;
      timer_in     = timer_ff;
      dir_in       = dir_ff;
      enable_in    = enable_ff;

      // step divider and edge count
      if (div_cnt_ff >= cfg.step_divider) begin
         div_cnt_in  = '0;
         step_pin_in = ~step_pin_ff;
         if (counting_ff && edges_ff != EDGES_MAX) begin
            edges_in = edges_ff + 1'b1;
         end
      end else begin
         div_cnt_in = div_cnt_ff + 1'b1;
      end

      below_bottom = 33'(edges_in) < 33'(cfg.bottom_steps);

      if (wait_kind_ff != WAIT_NONE) begin
         if (timer_ff != '0) begin
            timer_in = timer_ff - 1'b1;
         end else begin
            wait_kind_in = WAIT_NONE;
            case (wait_kind_ff)
               WAIT_CONFIRM: begin
                  case (mode_ff)
                     MODE_UP: begin
                        if (tick.projector_on) begin
                           mode_in     = MODE_LOWERING;
                           counting_in = 1'b1;
                        end
                     end
                     MODE_LOWERING: begin
                        if (!tick.projector_on) begin
                           mode_in     = MODE_RAISING;
                           counting_in = 1'b0;
                           edges_in    = '0;
                        end
                     end
                     MODE_DOWN: begin
                        if (!tick.projector_on) begin
                           mode_in     = MODE_RAISING;
                           counting_in = 1'b0;
                           edges_in    = '0;
                        end
                        jog_check = 1'b1;
                     end
                     default: mode_in = mode_ff;
                  endcase
               end
               WAIT_JOG_DOWN: begin
                  enable_in = 1'b0;
                  up_check  = 1'b1;
               end
               WAIT_JOG_UP: begin
                  enable_in = 1'b0;
                  dir_in    = 1'b1;
               end
               default: wait_kind_in = WAIT_NONE;
            endcase
         end
      end else begin
         case (mode_ff)
            MODE_INIT: mode_in = MODE_RAISING;
            MODE_RAISING: begin
               if (!tick.at_top) begin
                  dir_in    = 1'b0;
                  enable_in = 1'b1;
               end else begin
                  enable_in = 1'b0;
                  mode_in   = MODE_UP;
               end
            end
            MODE_UP: begin
               if (tick.projector_on) begin
                  wait_kind_in = WAIT_CONFIRM;
                  timer_in     = clamp_ticks(cfg.confirm_on_ticks);
               end
            end
            MODE_LOWERING: begin
               if (!tick.projector_on) begin
                  wait_kind_in = WAIT_CONFIRM;
                  timer_in     = clamp_ticks(cfg.confirm_off_ticks);
               end else if (below_bottom) begin
                  dir_in    = 1'b1;
                  enable_in = 1'b1;
               end else begin
                  enable_in   = 1'b0;
                  mode_in     = MODE_DOWN;
                  counting_in = 1'b0;
               end
            end
            MODE_DOWN: begin
               if (!tick.projector_on) begin
                  wait_kind_in = WAIT_CONFIRM;
                  timer_in     = clamp_ticks(cfg.confirm_off_ticks);
               end else begin
                  jog_check = 1'b1;
               end
            end
            default: mode_in = MODE_RAISING;
         endcase
      end

      // manual jog buttons
      if (jog_check) begin
         if (tick.jog_down_pressed) begin
            enable_in    = 1'b1;
            wait_kind_in = WAIT_JOG_DOWN;
            timer_in     = clamp_ticks(cfg.jog_ticks);
         end else begin
            up_check = 1'b1;
         end
      end
      if (up_check && tick.jog_up_pressed && !tick.at_top) begin
         dir_in       = 1'b0;
         enable_in    = 1'b1;
         wait_kind_in = WAIT_JOG_UP;
         timer_in     = clamp_ticks(cfg.jog_ticks);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_INIT;
         wait_kind_ff <= WAIT_NONE;
         step_pin_ff  <= 1'b0;
         div_cnt_ff   <= '0;
         edges_ff     <= '0;
         counting_ff  <= 1'b0;
         timer_ff     <= '0;
         dir_ff       <= 1'b0;
         enable_ff    <= 1'b0;
      end else if (advance) begin
         mode_ff      <= mode_in;
         wait_kind_ff <= wait_kind_in;
         step_pin_ff  <= step_pin_in;
         div_cnt_ff   <= div_cnt_in;
         edges_ff     <= edges_in;
         counting_ff  <= counting_in;
         timer_ff     <= timer_in;
         dir_ff       <= dir_in;
         enable_ff    <= enable_in;
      end
   end

   assign result.step_level     = step_pin_in;
   assign result.direction_down = dir_in;
   assign result.motor_enable   = enable_in;
   assign result.mode_code      = mode_in;

   a_counting_only_lowering: assert property (@(posedge clock) disable iff (reset)
      counting_ff |-> mode_ff == MODE_LOWERING)
      else $error("edge counting outside lowering");

   a_edges_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(edges_ff))
      else $error("edge count moved without a word");

   a_jog_up_drive: assert property (@(posedge clock) disable iff (reset)
      wait_kind_ff == WAIT_JOG_UP |-> enable_ff && !dir_ff)
      else $error("up jog without upward drive");

   a_jog_down_drive: assert property (@(posedge clock) disable iff (reset)
      wait_kind_ff == WAIT_JOG_DOWN |-> enable_ff)
      else $error("down jog without drive enabled");

endmodule

### design/stepper_screen_lift_controller_unit.sv
// top level of the stepper screen lift controller
// an accepted word is registered in the input stage, then its result in the result register behind rsp_valid
// throughput: one word per cycle unless the result stalls; input and result registers decouple the two channels
// a stalled result register holds the input stage, which then holds req_ready low
// reset is synchronous and active high; it restores register defaults and the init mode
module stepper_screen_lift_controller_unit
   import sslc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_projector_on,
   input  logic                      req_at_top,
   input  logic                      req_jog_down_pressed,
   input  logic                      req_jog_up_pressed,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_step_level,
   output logic                      rsp_direction_down,
   output logic                      rsp_motor_enable,
   output logic [2:0]                rsp_mode_code,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready
);

   cfg_type    cfg;
   tick_type   tick_ff, tick_in;
   logic       tick_valid_ff, tick_valid_in;
   result_type rsp_ff, rsp_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       advance;
   logic       out_free;
   logic       req_take;

   sslc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   sslc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .tick    (tick_ff),
      .cfg     (cfg),
      .result  (rsp_in)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = tick_valid_ff && out_free;
   assign req_ready = !tick_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   assign tick_in.projector_on     = req_projector_on;
   assign tick_in.at_top           = req_at_top;
   assign tick_in.jog_down_pressed = req_jog_down_pressed;
   assign tick_in.jog_up_pressed   = req_jog_up_pressed;

   assign tick_valid_in = req_take || (tick_valid_ff && !advance);
   assign rsp_valid_in  = advance || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         tick_valid_ff <= tick_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         tick_ff <= tick_in;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_step_level     = rsp_ff.step_level;
   assign rsp_direction_down = rsp_ff.direction_down;
   assign rsp_motor_enable   = rsp_ff.motor_enable;
   assign rsp_mode_code      = rsp_ff.mode_code;

endmodule
